/* hdl/cesc_pkg.sv */
`timescale 1ns / 1ps

package cesc_pkg;

  // character codes
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] PARAM_LO    = 8'h30;
  localparam logic [7:0] PARAM_HI    = 8'h3F;
  localparam logic [7:0] INTERM_LO   = 8'h20;
  localparam logic [7:0] INTERM_HI   = 8'h2F;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;

  // parser mode
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_PARAM  = 2'd2,
    MODE_INTERM = 2'd3
  } mode_t;

  // what one incoming byte does to the held sequence
  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_HOLD  = 2'd1,
    ACT_DROP  = 2'd2,
    ACT_BREAK = 2'd3
  } act_kind_t;

  typedef struct packed {
    act_kind_t kind;
    mode_t     mode;
  } action_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_READ = 3'd1,
    S_EMIT = 3'd2,
    S_TAIL = 3'd3,
    S_DONE = 3'd4
  } state_t;

endpackage

/* hdl/csi_escape_stripper_top.sv */
`timescale 1ns / 1ps

// Removes complete CSI control sequences (ESC '[' params intermediates final)
// from a byte stream. One request on the input channel carries a byte and an
// end-of-buffer flag; the output channel carries the bytes that survive, with
// has_byte, run_last (last result of this request) and buffer_end.
// Bytes of a candidate sequence are held in a small RAM; a byte that breaks
// the pattern, a full buffer, or end of buffer sends them out unchanged.
// A byte that passes straight through goes via the tail state into the
// output register once that is free; the next request is taken after that.
// A release reads each held byte from the RAM (read state) and then loads
// it into the output register (emit state). A byte that is held or ends a
// sequence gives no result unless it carries end of buffer.
// The input is ready only between requests; the output register
// lets the next request be taken while the last result waits.
// A stalled receiver freezes the sequencer with the result held in place.
// Reset returns the parser to idle with an empty buffer; no clearing pass
// is needed since only entries below the fill count are ever read.
module csi_escape_stripper_top #(
  parameter int MAX_SEQ = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       buffer_end
);

  localparam int CNT_W  = $clog2(MAX_SEQ + 1);
  localparam int ADDR_W = $clog2(MAX_SEQ);

  cesc_pkg::state_t  state, state_next;
  cesc_pkg::mode_t   mode, mode_next;
  cesc_pkg::action_t act;

  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  drain_n, drain_n_next;
  logic [7:0]        byte_r, byte_r_next;
  logic              eob_r, eob_r_next;
  logic              tail_en, tail_en_next;
  logic              tail_has, tail_has_next;
  logic              hold_after, hold_after_next;

  logic              out_valid_next;
  logic [7:0]        out_byte_next;
  logic              has_byte_next;
  logic              run_last_next;
  logic              buffer_end_next;

  logic              can_hold;
  logic              out_free;
  logic              last_idx;
  logic              emit_last;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [7:0]        rd_data;

  assign can_hold  = count < CNT_W'(MAX_SEQ);
  assign out_free  = !out_valid || out_ready;
  assign last_idx  = (CNT_W'(idx + 1'b1) == drain_n);
  assign emit_last = last_idx && !tail_en;

  cesc_classify u_classify (
    .in_byte  (in_byte),
    .mode     (mode),
    .can_hold (can_hold),
    .act      (act)
  );

  // held sequence bytes
  cesc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SEQ)
  ) u_pending (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cesc_pkg::S_IDLE;
      mode      <= cesc_pkg::MODE_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // sequencer working registers and output payload
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    drain_n    <= drain_n_next;
    byte_r     <= byte_r_next;
    eob_r      <= eob_r_next;
    tail_en    <= tail_en_next;
    tail_has   <= tail_has_next;
    hold_after <= hold_after_next;
    out_byte   <= out_byte_next;
    has_byte   <= has_byte_next;
    run_last   <= run_last_next;
    buffer_end <= buffer_end_next;
  end

  // next state and outputs
  always_comb begin
    state_next      = state;
    mode_next       = mode;
    count_next      = count;
    idx_next        = idx;
    drain_n_next    = drain_n;
    byte_r_next     = byte_r;
    eob_r_next      = eob_r;
    tail_en_next    = tail_en;
    tail_has_next   = tail_has;
    hold_after_next = hold_after;
    out_valid_next  = out_valid && !out_ready;
    out_byte_next   = out_byte;
    has_byte_next   = has_byte;
    run_last_next   = run_last;
    buffer_end_next = buffer_end;
    we              = 1'b0;
    waddr           = count[ADDR_W-1:0];
    wdata           = in_byte;
    in_ready        = (state == cesc_pkg::S_IDLE);

    case (state)
      cesc_pkg::S_IDLE: begin
        if (in_valid) begin
          byte_r_next     = in_byte;
          eob_r_next      = end_of_buffer;
          idx_next        = '0;
          tail_en_next    = 1'b0;
          tail_has_next   = 1'b1;
          hold_after_next = 1'b0;
          case (act.kind)
            cesc_pkg::ACT_HOLD: begin
              we = 1'b1;
              if (end_of_buffer) begin
                drain_n_next = CNT_W'(count + 1'b1);
                count_next   = '0;
                mode_next    = cesc_pkg::MODE_IDLE;
                state_next   = cesc_pkg::S_READ;
              end else begin
                count_next = CNT_W'(count + 1'b1);
                mode_next  = act.mode;
              end
            end
            cesc_pkg::ACT_DROP: begin
              count_next = '0;
              mode_next  = cesc_pkg::MODE_IDLE;
              if (end_of_buffer) begin
                tail_en_next  = 1'b1;
                tail_has_next = 1'b0;
                byte_r_next   = 8'h00;
                state_next    = cesc_pkg::S_TAIL;
              end
            end
            cesc_pkg::ACT_BREAK: begin
              drain_n_next = count;
              count_next   = '0;
              mode_next    = cesc_pkg::MODE_IDLE;
              state_next   = cesc_pkg::S_READ;
              // an ESC that breaks the pattern starts a new sequence, unless it ends the buffer
              if (in_byte == cesc_pkg::CH_ESC && !end_of_buffer) begin
                hold_after_next = 1'b1;
              end else begin
                tail_en_next = 1'b1;
              end
            end
            default: begin
              tail_en_next = 1'b1;
              state_next   = cesc_pkg::S_TAIL;
            end
          endcase
        end
      end

      cesc_pkg::S_READ: begin
        state_next = cesc_pkg::S_EMIT;
      end

      // release one held byte per pass
      cesc_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_byte_next   = rd_data;
          has_byte_next   = 1'b1;
          run_last_next   = emit_last;
          buffer_end_next = emit_last && eob_r;
          idx_next        = CNT_W'(idx + 1'b1);
          if (last_idx) begin
            if (tail_en) begin
              state_next = cesc_pkg::S_TAIL;
            end else if (hold_after) begin
              state_next = cesc_pkg::S_DONE;
            end else begin
              state_next = cesc_pkg::S_IDLE;
            end
          end else begin
            state_next = cesc_pkg::S_READ;
          end
        end
      end

      // the request's own byte, or a bare end marker
      cesc_pkg::S_TAIL: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_byte_next   = byte_r;
          has_byte_next   = tail_has;
          run_last_next   = 1'b1;
          buffer_end_next = eob_r;
          state_next      = cesc_pkg::S_IDLE;
        end
      end

      // hold the breaking ESC as the start of a new sequence
      cesc_pkg::S_DONE: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = byte_r;
        count_next = CNT_W'(1);
        mode_next  = cesc_pkg::MODE_ESC;
        state_next = cesc_pkg::S_IDLE;
      end

      default: begin
        state_next = cesc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/cesc_ram.sv */
`timescale 1ns / 1ps

module cesc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/cesc_classify.sv */
`timescale 1ns / 1ps

module cesc_classify (
  input  logic                 [7:0] in_byte,
  input  cesc_pkg::mode_t            mode,
  input  logic                       can_hold,
  output cesc_pkg::action_t          act
);

  logic is_param;
  logic is_interm;
  logic is_final;

  // byte classes of a control sequence
  assign is_param  = (in_byte >= cesc_pkg::PARAM_LO) && (in_byte <= cesc_pkg::PARAM_HI);
  assign is_interm = (in_byte >= cesc_pkg::INTERM_LO) && (in_byte <= cesc_pkg::INTERM_HI);
  assign is_final  = (in_byte >= cesc_pkg::FINAL_LO) && (in_byte <= cesc_pkg::FINAL_HI);

  // pattern step: hold, drop the whole sequence, pass, or break it
  always_comb begin
    act.kind = cesc_pkg::ACT_PASS;
    act.mode = cesc_pkg::MODE_IDLE;
    case (mode)
      cesc_pkg::MODE_IDLE: begin
        if (in_byte == cesc_pkg::CH_ESC && can_hold) begin
          act.kind = cesc_pkg::ACT_HOLD;
          act.mode = cesc_pkg::MODE_ESC;
        end
      end
      cesc_pkg::MODE_ESC: begin
        if (in_byte == cesc_pkg::CH_LBRACKET && can_hold) begin
          act.kind = cesc_pkg::ACT_HOLD;
          act.mode = cesc_pkg::MODE_PARAM;
        end else begin
          act.kind = cesc_pkg::ACT_BREAK;
        end
      end
      cesc_pkg::MODE_PARAM: begin
        if (is_param && can_hold) begin
          act.kind = cesc_pkg::ACT_HOLD;
          act.mode = cesc_pkg::MODE_PARAM;
        end else if (is_interm && can_hold) begin
          act.kind = cesc_pkg::ACT_HOLD;
          act.mode = cesc_pkg::MODE_INTERM;
        end else if (is_final) begin
          act.kind = cesc_pkg::ACT_DROP;
        end else begin
          act.kind = cesc_pkg::ACT_BREAK;
        end
      end
      default: begin
        if (is_interm && can_hold) begin
          act.kind = cesc_pkg::ACT_HOLD;
          act.mode = cesc_pkg::MODE_INTERM;
        end else if (is_final) begin
          act.kind = cesc_pkg::ACT_DROP;
        end else begin
          act.kind = cesc_pkg::ACT_BREAK;
        end
      end
    endcase
  end

endmodule

/* test/tb_csi_escape_stripper_top.sv */
`timescale 1ns / 1ps

// tracks the expected filtered stream and checks each output result
class strip_scoreboard;
  typedef struct packed {
    logic [7:0] data;
    logic       valid_byte;
    logic       last_of_req;
    logic       end_of_buf;
  } strip_result_t;

  cesc_pkg::mode_t mode;
  logic [7:0]      held_bytes[$];
  strip_result_t   burst[$];
  strip_result_t   filtered_q[$];
  int              hold_depth;
  int              errors;
  int              results_seen;
  int              requests_seen;
  int              overflows;
  int              drops;
  int              bare_markers;

  function new(int depth);
    hold_depth    = depth;
    mode          = cesc_pkg::MODE_IDLE;
    errors        = 0;
    results_seen  = 0;
    requests_seen = 0;
    overflows     = 0;
    drops         = 0;
    bare_markers  = 0;
  endfunction

  function bit is_param(logic [7:0] b);
    return b >= cesc_pkg::PARAM_LO && b <= cesc_pkg::PARAM_HI;
  endfunction

  function bit is_interm(logic [7:0] b);
    return b >= cesc_pkg::INTERM_LO && b <= cesc_pkg::INTERM_HI;
  endfunction

  function bit is_final(logic [7:0] b);
    return b >= cesc_pkg::FINAL_LO && b <= cesc_pkg::FINAL_HI;
  endfunction

  // append to the pending buffer unless it is full
  function bit try_hold(logic [7:0] b);
    if (held_bytes.size() < hold_depth) begin
      held_bytes.push_back(b);
      return 1'b1;
    end
    overflows++;
    return 1'b0;
  endfunction

  // send the held bytes out unchanged and go back to idle
  function void flush_held();
    foreach (held_bytes[i]) burst.push_back('{held_bytes[i], 1'b1, 1'b0, 1'b0});
    held_bytes.delete();
    mode = cesc_pkg::MODE_IDLE;
  endfunction

  // sequence completed: held bytes and final byte vanish
  function void drop_sequence();
    held_bytes.delete();
    mode = cesc_pkg::MODE_IDLE;
    drops++;
  endfunction

  // predict the results of one accepted request
  function void strip_byte(logic [7:0] b, logic eob);
    bit            again;
    strip_result_t r;
    requests_seen++;
    burst.delete();
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (mode)
        cesc_pkg::MODE_IDLE: begin
          if (b == cesc_pkg::CH_ESC && try_hold(b)) mode = cesc_pkg::MODE_ESC;
          else burst.push_back('{b, 1'b1, 1'b0, 1'b0});
        end
        cesc_pkg::MODE_ESC: begin
          if (b == cesc_pkg::CH_LBRACKET && try_hold(b)) begin
            mode = cesc_pkg::MODE_PARAM;
          end else begin
            flush_held();
            again = 1'b1;
          end
        end
        cesc_pkg::MODE_PARAM: begin
          if (is_param(b) && try_hold(b)) begin
            mode = cesc_pkg::MODE_PARAM;
          end else if (is_interm(b) && try_hold(b)) begin
            mode = cesc_pkg::MODE_INTERM;
          end else if (is_final(b)) begin
            drop_sequence();
          end else begin
            flush_held();
            again = 1'b1;
          end
        end
        default: begin
          if (is_interm(b) && try_hold(b)) begin
            mode = cesc_pkg::MODE_INTERM;
          end else if (is_final(b)) begin
            drop_sequence();
          end else begin
            flush_held();
            again = 1'b1;
          end
        end
      endcase
    end
    // end of buffer flushes; a bare marker if nothing came out
    if (eob) begin
      flush_held();
      if (burst.size() == 0) begin
        burst.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
        bare_markers++;
      end
    end
    if (burst.size() > 0) begin
      r = burst[burst.size() - 1];
      r.last_of_req = 1'b1;
      r.end_of_buf  = eob;
      burst[burst.size() - 1] = r;
    end
    foreach (burst[i]) filtered_q.push_back(burst[i]);
  endfunction

  task report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // compare one accepted result with the oldest expectation
  task check_result(logic [7:0] data, logic valid_byte, logic last_of_req,
                    logic end_of_buf);
    strip_result_t exp_r;
    results_seen++;
    if (filtered_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte %02h", data));
    end else begin
      exp_r = filtered_q.pop_front();
      if (valid_byte !== exp_r.valid_byte)
        report_mismatch($sformatf("has_byte %b, want %b", valid_byte, exp_r.valid_byte));
      if (exp_r.valid_byte && data !== exp_r.data)
        report_mismatch($sformatf("out_byte %02h, want %02h", data, exp_r.data));
      if (!exp_r.valid_byte && data !== exp_r.data)
        report_mismatch($sformatf("marker out_byte %02h, want %02h", data, exp_r.data));
      if (last_of_req !== exp_r.last_of_req)
        report_mismatch($sformatf("run_last %b, want %b", last_of_req, exp_r.last_of_req));
      if (end_of_buf !== exp_r.end_of_buf)
        report_mismatch($sformatf("buffer_end %b, want %b", end_of_buf, exp_r.end_of_buf));
    end
  endtask
endclass

module tb_csi_escape_stripper_top;

  typedef logic [7:0] byte_q_t[$];

  localparam int HOLD_DEPTH   = 32;
  localparam int RANDOM_ITEMS = 460;
  localparam int CYCLE_LIMIT  = 400000;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte       = 8'h00;
  logic       end_of_buffer = 1'b0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       buffer_end;

  strip_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_count     = 0;
  int directed_count = 0;
  int cycle_count    = 0;

  csi_escape_stripper_top #(
    .MAX_SEQ(HOLD_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_buffer(end_of_buffer),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .run_last     (run_last),
    .buffer_end   (buffer_end)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: check accepted results, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(out_byte, has_byte, run_last, buffer_end);
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // one request, with optional idle cycles before it
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_buffer <= eob;
    do @(posedge clk); while (!in_ready);
    sb.strip_byte(b, eob);
    sent_count++;
  endtask

  // a byte string; end of buffer only on its last byte if asked
  task automatic send_bytes(input byte_q_t seq, input logic eob_last);
    foreach (seq[i]) send_byte(seq[i], eob_last && (i == seq.size() - 1));
  endtask

  // random sequence body length: mostly short, sometimes near the buffer size
  function automatic int body_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(26, 34);
    return $urandom_range(0, 4);
  endfunction

  // random traffic: well-formed sequences, broken ones and noise
  task automatic send_random(input int target);
    byte_q_t seq;
    int      kind;
    int      n_par;
    int      n_int;
    int      cut;
    while (sent_count < target) begin
      seq.delete();
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        n_par = body_len();
        n_int = ($urandom_range(0, 3) == 0) ? body_len() : $urandom_range(0, 2);
        seq.push_back(cesc_pkg::CH_ESC);
        seq.push_back(cesc_pkg::CH_LBRACKET);
        repeat (n_par)
          seq.push_back(8'($urandom_range(cesc_pkg::PARAM_LO, cesc_pkg::PARAM_HI)));
        repeat (n_int)
          seq.push_back(8'($urandom_range(cesc_pkg::INTERM_LO, cesc_pkg::INTERM_HI)));
        seq.push_back(8'($urandom_range(cesc_pkg::FINAL_LO, cesc_pkg::FINAL_HI)));
        // broken sequence: cut short and end with any byte
        if (kind >= 60) begin
          cut = $urandom_range(1, seq.size() - 1);
          while (seq.size() > cut) seq.pop_back();
          seq.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 4) == 0) seq.push_back(cesc_pkg::CH_ESC);
          else seq.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (seq[i]) send_byte(seq[i], $urandom_range(0, 15) == 0);
    end
  endtask

  // main sequence
  initial begin
    int quarter;
    sb = new(HOLD_DEPTH);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, drops, breaks, flushes, bare marker
    send_bytes('{8'h00}, 1'b0);
    send_bytes('{cesc_pkg::CH_ESC, cesc_pkg::CH_LBRACKET, cesc_pkg::PARAM_LO,
                 cesc_pkg::INTERM_HI, cesc_pkg::FINAL_LO}, 1'b0);
    send_bytes('{cesc_pkg::CH_ESC, cesc_pkg::CH_LBRACKET, cesc_pkg::PARAM_HI,
                 cesc_pkg::INTERM_LO, cesc_pkg::FINAL_HI}, 1'b1);
    send_bytes('{cesc_pkg::CH_ESC, cesc_pkg::CH_LBRACKET, 8'h7F}, 1'b0);
    send_bytes('{cesc_pkg::CH_ESC, cesc_pkg::CH_ESC, 8'hFF}, 1'b0);
    send_bytes('{cesc_pkg::CH_ESC, cesc_pkg::CH_LBRACKET, cesc_pkg::INTERM_LO,
                 cesc_pkg::PARAM_LO}, 1'b0);
    send_bytes('{cesc_pkg::CH_ESC}, 1'b1);
    send_bytes('{8'h41}, 1'b1);
    directed_count = sent_count;

    // random traffic over the handshake phases
    quarter = RANDOM_ITEMS / 4;
    send_random(directed_count + quarter);
    send_idle_pct  = 51;
    recv_stall_pct = 0;
    send_random(directed_count + 2 * quarter);
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    send_random(directed_count + 3 * quarter);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    send_random(directed_count + RANDOM_ITEMS);
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (sb.filtered_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d requests (%0d directed) over four handshake phases, %0d results",
             sb.requests_seen, directed_count, sb.results_seen);
    $display("sequences stripped %0d, buffer overflows %0d, bare end markers %0d",
             sb.drops, sb.overflows, sb.bare_markers);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
